// ----- hdl/acs_pkg.sv -----
// acs_pkg: shared constants and types for the adc channel sequencer/averager
// used by acs_avg_div and adc_channel_sequencer_averager; no dependencies
package acs_pkg;

    localparam int ACS_BRIDGE_SAMPLES     = 16;
    localparam int ACS_THERMISTOR_SAMPLES = 8;
    localparam int ACS_DISCARD_COUNT      = 2;

    localparam int SAMPLE_W = 24;
    localparam int CHAN_W   = 3;
    localparam int IDX_W    = 8;
    localparam int HOLD_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_CHANNEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_THIRD   = 1'b1;

    localparam logic [CHAN_W-1:0] CH_BRIDGE0 = 3'd0;
    localparam logic [CHAN_W-1:0] CH_BRIDGE1 = 3'd1;
    localparam logic [CHAN_W-1:0] CH_BRIDGE2 = 3'd2;
    localparam logic [CHAN_W-1:0] CH_THERM0  = 3'd3;
    localparam logic [CHAN_W-1:0] CH_THERM1  = 3'd4;
    localparam logic [CHAN_W-1:0] NUM_CHANNELS = 3'd5;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [CHAN_W-1:0] next_channel;
        logic              held;
        logic              thermistor;
    } t_blk_info;

endpackage

// ----- hdl/adc_channel_sequencer_averager.sv -----
// adc_channel_sequencer_averager: five-channel converter sequencer with block averaging
// depends on acs_pkg and acs_avg_div
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | i_in_valid / o_in_ready | i_sample
//  out     | o_out_valid/i_out_ready | o_channel, o_average, o_next_channel, o_held
//  cfg     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// one sample is taken every cycle while o_in_ready is high; accumulation and counting finish in the accept cycle.
// a finished block passes the block register, then the combinational divider and the result register.
// reset (synchronous, active low) starts on the first bridge input with no discard.
// a stalled output fills the block register, then input ready drops.
module adc_channel_sequencer_averager
    import acs_pkg::*;
#(
    parameter int BRIDGE_SAMPLES     = ACS_BRIDGE_SAMPLES,
    parameter int THERMISTOR_SAMPLES = ACS_THERMISTOR_SAMPLES,
    parameter int DISCARD_COUNT      = ACS_DISCARD_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_channel,
    output logic [SAMPLE_W-1:0]   o_average,
    output logic [CHAN_W-1:0]     o_next_channel,
    output logic                  o_held
);

    localparam int MAX_SAMPLES = (BRIDGE_SAMPLES > THERMISTOR_SAMPLES) ?
                                 BRIDGE_SAMPLES : THERMISTOR_SAMPLES;
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam logic [IDX_W-1:0] DISCARD_RELOAD = IDX_W'(256 - DISCARD_COUNT);
    localparam logic [IDX_W-1:0] BLOCK_B = IDX_W'(BRIDGE_SAMPLES);
    localparam logic [IDX_W-1:0] BLOCK_T = IDX_W'(THERMISTOR_SAMPLES);

    logic [HOLD_W-1:0] r_hold;
    logic              r_skip;
    logic [CHAN_W-1:0] r_ch;
    logic [IDX_W-1:0]  r_idx;
    logic [SUM_W-1:0]  r_sum;
    logic              r_s1_valid;
    t_blk_info         r_s1_info;
    logic [SUM_W-1:0]  r_s1_sum;
    logic              r_out_valid;

    logic [CHAN_W-1:0]   ch_eff;
    logic                therm;
    logic [IDX_W-1:0]    block_len;
    logic [IDX_W-1:0]    idx_inc;
    logic                discarding;
    logic                done;
    logic [SUM_W-1:0]    sample_ext;
    logic [SUM_W-1:0]    n_sum;
    logic                hold;
    logic [CHAN_W-1:0]   follow;
    logic [CHAN_W-1:0]   n_ch;
    logic                accept;
    logic                s1_take;
    logic [SAMPLE_W-1:0] avg;

    assign ch_eff     = (r_ch >= NUM_CHANNELS) ? CH_BRIDGE0 : r_ch;
    assign therm      = (ch_eff >= CH_THERM0);
    assign block_len  = therm ? BLOCK_T : BLOCK_B;
    assign idx_inc    = r_idx + IDX_W'(1);
    assign discarding = (r_idx >= block_len);
    assign done       = !discarding && (idx_inc == block_len);
    assign sample_ext = therm ? SUM_W'(i_sample[SAMPLE_W-1:8]) : SUM_W'(i_sample);
    assign n_sum      = r_sum + sample_ext;
    assign hold       = ({1'b0, r_hold} == ({1'b0, ch_eff} + 4'd1));

    always_comb begin
        unique case (ch_eff)
            CH_BRIDGE0: follow = CH_BRIDGE1;
            CH_BRIDGE1: follow = r_skip ? CH_THERM0 : CH_BRIDGE2;
            CH_BRIDGE2: follow = CH_THERM0;
            CH_THERM0:  follow = CH_THERM1;
            default:    follow = CH_BRIDGE0;
        endcase
    end

    assign n_ch = hold ? ch_eff : follow;

    assign s1_take    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_take;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_skip <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HOLD_CHANNEL: r_hold <= i_cfg_data[HOLD_W-1:0];
                REG_SKIP_THIRD:   r_skip <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch  <= CH_BRIDGE0;
            r_idx <= '0;
            r_sum <= '0;
        end else if (accept) begin
            priority if (discarding) begin
                r_idx <= idx_inc;
            end else if (done) begin
                r_ch  <= n_ch;
                r_idx <= DISCARD_RELOAD;
                r_sum <= '0;
            end else begin
                r_idx <= idx_inc;
                r_sum <= n_sum;
            end
        end
    end

    // finished block register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && done) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && done) begin
            r_s1_sum               <= n_sum;
            r_s1_info.channel      <= ch_eff;
            r_s1_info.next_channel <= n_ch;
            r_s1_info.held         <= hold;
            r_s1_info.thermistor   <= therm;
        end
    end

    acs_avg_div #(
        .BRIDGE_SAMPLES     (BRIDGE_SAMPLES),
        .THERMISTOR_SAMPLES (THERMISTOR_SAMPLES),
        .SUM_W              (SUM_W)
    ) u_avg_div (
        .i_sum        (r_s1_sum),
        .i_thermistor (r_s1_info.thermistor),
        .o_average    (avg)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            o_channel      <= r_s1_info.channel;
            o_average      <= avg;
            o_next_channel <= r_s1_info.next_channel;
            o_held         <= r_s1_info.held;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/acs_avg_div.sv -----
// acs_avg_div: block mean, running sum divided by the block length of the channel
// constant reciprocal multiply, exact for any sum below 2**SUM_W; uses acs_pkg
module acs_avg_div
    import acs_pkg::*;
#(
    parameter int BRIDGE_SAMPLES     = ACS_BRIDGE_SAMPLES,
    parameter int THERMISTOR_SAMPLES = ACS_THERMISTOR_SAMPLES,
    parameter int SUM_W              = 28
) (
    input  logic [SUM_W-1:0]    i_sum,
    input  logic                i_thermistor,
    output logic [SAMPLE_W-1:0] o_average
);

    localparam int L_B    = $clog2(BRIDGE_SAMPLES);
    localparam int L_T    = $clog2(THERMISTOR_SAMPLES);
    localparam int SH_B   = SUM_W + L_B;
    localparam int SH_T   = SUM_W + L_T;
    localparam int M_W    = SUM_W + 1;
    localparam int PROD_W = SUM_W + M_W;
    localparam logic [63:0] M_B =
        ((64'd1 << SH_B) + 64'(BRIDGE_SAMPLES) - 64'd1) / 64'(BRIDGE_SAMPLES);
    localparam logic [63:0] M_T =
        ((64'd1 << SH_T) + 64'(THERMISTOR_SAMPLES) - 64'd1) / 64'(THERMISTOR_SAMPLES);

    logic [PROD_W-1:0] prod_b;
    logic [PROD_W-1:0] prod_t;
    logic [PROD_W-1:0] quot_b;
    logic [PROD_W-1:0] quot_t;

    assign prod_b = PROD_W'(i_sum) * PROD_W'(M_B[M_W-1:0]);
    assign prod_t = PROD_W'(i_sum) * PROD_W'(M_T[M_W-1:0]);
    assign quot_b = prod_b >> SH_B;
    assign quot_t = prod_t >> SH_T;

    assign o_average = i_thermistor ? quot_t[SAMPLE_W-1:0] : quot_b[SAMPLE_W-1:0];

endmodule
